// ===== rtl/bbm_pkg.sv =====
package bbm_pkg;

	localparam int AXES_MAX = 2;
	localparam int COORD_W = 16;
	localparam int EXT_W = 16;
	localparam int AD_W = 17;
	localparam int SQ_W = 34;
	localparam int VOL_W = 32;
	localparam int RAD_W = 36;
	localparam int ROOT_W = 18;
	localparam int REM_W = ROOT_W + 4;
	localparam int SQ_STEPS = 3;
	localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
	localparam int GEOM_STAGES = 4;
	localparam int LATENCY = GEOM_STAGES + SQ_STAGES;

	typedef struct packed {
		logic signed [COORD_W-1:0] box_a_x_end0;
		logic signed [COORD_W-1:0] box_a_x_end1;
		logic signed [COORD_W-1:0] box_a_y_end0;
		logic signed [COORD_W-1:0] box_a_y_end1;
		logic signed [COORD_W-1:0] box_b_x_end0;
		logic signed [COORD_W-1:0] box_b_x_end1;
		logic signed [COORD_W-1:0] box_b_y_end0;
		logic signed [COORD_W-1:0] box_b_y_end1;
	} boxes_t;

	typedef struct packed {
		logic [VOL_W-1:0] volume_a;
		logic [VOL_W-1:0] expansion;
		logic [VOL_W-1:0] overlap_area;
		logic             b_inside_a;
		logic [ROOT_W-1:0] centroid_distance;
	} metrics_t;

	typedef struct packed {
		logic [VOL_W-1:0] volume_a;
		logic [VOL_W-1:0] expansion;
		logic [VOL_W-1:0] overlap_area;
		logic             b_inside_a;
	} area_t;

	typedef struct packed {
		logic             valid;
		area_t            area;
		logic [RAD_W-1:0] sumsq;
	} geom_t;

endpackage

// ===== rtl/bbm_geom.sv =====
module bbm_geom #(
	parameter int AXES = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bbm_pkg::boxes_t  boxes,
	output bbm_pkg::geom_t   geom
);

	localparam int N = bbm_pkg::AXES_MAX;
	localparam int CW = bbm_pkg::COORD_W;
	localparam int EW = bbm_pkg::EXT_W;
	localparam int AW = bbm_pkg::AD_W;
	localparam int QW = bbm_pkg::SQ_W;
	localparam int VW = bbm_pkg::VOL_W;
	localparam int RW = bbm_pkg::RAD_W;

	logic signed [CW-1:0] ra0 [N];
	logic signed [CW-1:0] ra1 [N];
	logic signed [CW-1:0] rb0 [N];
	logic signed [CW-1:0] rb1 [N];

	logic                 v_s1;
	logic signed [CW-1:0] alo_s1 [N];
	logic signed [CW-1:0] ahi_s1 [N];
	logic signed [CW-1:0] blo_s1 [N];
	logic signed [CW-1:0] bhi_s1 [N];

	logic          v_s2;
	logic [EW-1:0] exa_s2 [N];
	logic [EW-1:0] exu_s2 [N];
	logic [EW-1:0] exo_s2 [N];
	logic [N-1:0]  opos_s2;
	logic [N-1:0]  ins_s2;
	logic [AW-1:0] ad_s2 [N];

	logic          v_s3;
	logic [VW-1:0] vola_s3;
	logic [VW-1:0] volu_s3;
	logic [VW-1:0] volo_s3;
	logic          ook_s3;
	logic          ins_s3;
	logic [QW-1:0] sq_s3 [N];

	logic                v_s4;
	bbm_pkg::area_t      area_s4;
	logic [RW-1:0]       sumsq_s4;

	assign ra0[0] = boxes.box_a_x_end0;
	assign ra1[0] = boxes.box_a_x_end1;
	assign ra0[1] = boxes.box_a_y_end0;
	assign ra1[1] = boxes.box_a_y_end1;
	assign rb0[0] = boxes.box_b_x_end0;
	assign rb1[0] = boxes.box_b_x_end1;
	assign rb0[1] = boxes.box_b_y_end0;
	assign rb1[1] = boxes.box_b_y_end1;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_axis
		logic signed [CW-1:0]   ulo;
		logic signed [CW-1:0]   uhi;
		logic signed [CW-1:0]   olo;
		logic signed [CW-1:0]   ohi;
		logic signed [CW:0]     da;
		logic signed [CW:0]     du;
		logic signed [CW:0]     dov;
		logic signed [CW:0]     sa;
		logic signed [CW:0]     sb;
		logic signed [CW+1:0]   df;
		logic [AW-1:0]          adv;
		logic                   in_use;

		assign in_use = (i < AXES);

		// stage 1: order the ends
		always_ff @(posedge clk) begin
			if (start) begin
				alo_s1[i] <= (ra0[i] < ra1[i]) ? ra0[i] : ra1[i];
				ahi_s1[i] <= (ra0[i] < ra1[i]) ? ra1[i] : ra0[i];
				blo_s1[i] <= (rb0[i] < rb1[i]) ? rb0[i] : rb1[i];
				bhi_s1[i] <= (rb0[i] < rb1[i]) ? rb1[i] : rb0[i];
			end
		end

		always_comb begin
			ulo = (alo_s1[i] < blo_s1[i]) ? alo_s1[i] : blo_s1[i];
			uhi = (ahi_s1[i] > bhi_s1[i]) ? ahi_s1[i] : bhi_s1[i];
			olo = (alo_s1[i] > blo_s1[i]) ? alo_s1[i] : blo_s1[i];
			ohi = (ahi_s1[i] < bhi_s1[i]) ? ahi_s1[i] : bhi_s1[i];
			da  = (CW+1)'(ahi_s1[i]) - (CW+1)'(alo_s1[i]);
			du  = (CW+1)'(uhi) - (CW+1)'(ulo);
			dov = (CW+1)'(ohi) - (CW+1)'(olo);
			sa  = (CW+1)'(ahi_s1[i]) + (CW+1)'(alo_s1[i]);
			sb  = (CW+1)'(bhi_s1[i]) + (CW+1)'(blo_s1[i]);
			df  = (CW+2)'(sa) - (CW+2)'(sb);
			adv = df[CW+1] ? AW'(-df) : AW'(df);
		end

		// stage 2: extents per axis, unused axes act as neutral
		always_ff @(posedge clk) begin
			if (v_s1) begin
				exa_s2[i]  <= in_use ? da[EW-1:0] : EW'(1);
				exu_s2[i]  <= in_use ? du[EW-1:0] : EW'(1);
				exo_s2[i]  <= in_use ? dov[EW-1:0] : EW'(1);
				opos_s2[i] <= in_use ? (!dov[CW] && (dov != '0)) : 1'b1;
				ins_s2[i]  <= in_use ? ((blo_s1[i] >= alo_s1[i]) && (bhi_s1[i] <= ahi_s1[i]))
					: 1'b1;
				ad_s2[i]   <= in_use ? adv : '0;
			end
		end

		// stage 3: squares
		always_ff @(posedge clk) begin
			if (v_s2) begin
				sq_s3[i] <= QW'(ad_s2[i]) * QW'(ad_s2[i]);
			end
		end
	end

	// stage 3: areas
	always_ff @(posedge clk) begin
		if (v_s2) begin
			vola_s3 <= VW'(exa_s2[0]) * VW'(exa_s2[1]);
			volu_s3 <= VW'(exu_s2[0]) * VW'(exu_s2[1]);
			volo_s3 <= VW'(exo_s2[0]) * VW'(exo_s2[1]);
			ook_s3  <= &opos_s2;
			ins_s3  <= &ins_s2;
		end
	end

	// stage 4: combine
	always_ff @(posedge clk) begin
		if (v_s3) begin
			area_s4.volume_a     <= vola_s3;
			area_s4.expansion    <= volu_s3 - vola_s3;
			area_s4.overlap_area <= ook_s3 ? volo_s3 : '0;
			area_s4.b_inside_a   <= ins_s3;
			sumsq_s4             <= RW'(sq_s3[0]) + RW'(sq_s3[1]);
		end
	end

	assign geom.valid = v_s4;
	assign geom.area  = area_s4;
	assign geom.sumsq = sumsq_s4;

endmodule

// ===== rtl/bbm_sqrt.sv =====
module bbm_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bbm_pkg::geom_t                 geom,
	output logic                           out_valid,
	output bbm_pkg::area_t                 out_area,
	output logic [bbm_pkg::ROOT_W-1:0]     out_root
);

	localparam int NS = bbm_pkg::SQ_STAGES;
	localparam int NK = bbm_pkg::SQ_STEPS;
	localparam int RW = bbm_pkg::RAD_W;
	localparam int MW = bbm_pkg::REM_W;
	localparam int QW = bbm_pkg::ROOT_W;

	logic           vld_s  [NS+1];
	bbm_pkg::area_t area_s [NS+1];
	logic [RW-1:0]  rad_s  [NS+1];
	logic [MW-1:0]  rem_s  [NS+1];
	logic [QW-1:0]  root_s [NS+1];

	assign vld_s[0]  = geom.valid;
	assign area_s[0] = geom.area;
	assign rad_s[0]  = geom.sumsq;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [RW-1:0] rad_n;
		logic [MW-1:0] rem_n;
		logic [QW-1:0] root_n;

		// restoring square root, one result bit per step
		always_comb begin
			logic [MW-1:0] r;
			logic [RW-1:0] d;
			logic [QW-1:0] q;
			logic [MW-1:0] t;
			r = rem_s[g];
			d = rad_s[g];
			q = root_s[g];
			for (int k = 0; k < NK; k++) begin
				r = {r[MW-3:0], d[RW-1 -: 2]};
				d = {d[RW-3:0], 2'b00};
				t = MW'({q, 2'b01});
				if (r >= t) begin
					r = r - t;
					q = {q[QW-2:0], 1'b1};
				end else begin
					q = {q[QW-2:0], 1'b0};
				end
			end
			rad_n  = d;
			rem_n  = r;
			root_n = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (vld_s[g]) begin
				area_s[g+1] <= area_s[g];
				rad_s[g+1]  <= rad_n;
				rem_s[g+1]  <= rem_n;
				root_s[g+1] <= root_n;
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign out_area  = area_s[NS];
	assign out_root  = root_s[NS];

endmodule

// ===== rtl/bounding_box_metrics.sv =====
// channel   signals          accepted when
// input     start, boxes     start high and busy low at a rising edge
// result    done, metrics    done high; held for that one cycle only
//
// the pipeline has 4 geometry stages (order ends, extents, multiply,
// combine) and 6 square root stages of 3 root bits each.
// one item can enter every cycle; busy is always low.
// arst_n clears only the valid bits; payload registers are not reset.
// results cannot be held off by the receiver, so the pipeline never stalls.
module bounding_box_metrics #(
	parameter int DIMENSIONS = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bbm_pkg::boxes_t   boxes,
	output logic              done,
	output bbm_pkg::metrics_t metrics
);

	localparam int AXES = (DIMENSIONS > bbm_pkg::AXES_MAX) ? bbm_pkg::AXES_MAX :
		((DIMENSIONS < 1) ? 1 : DIMENSIONS);

	bbm_pkg::geom_t geom;
	bbm_pkg::area_t area;
	logic [bbm_pkg::ROOT_W-1:0] root;

	assign busy = 1'b0;

	bbm_geom #(
		.AXES (AXES)
	) u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.boxes  (boxes),
		.geom   (geom)
	);

	bbm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.out_valid (done),
		.out_area  (area),
		.out_root  (root)
	);

	assign metrics.volume_a          = area.volume_a;
	assign metrics.expansion         = area.expansion;
	assign metrics.overlap_area      = area.overlap_area;
	assign metrics.b_inside_a        = area.b_inside_a;
	assign metrics.centroid_distance = root;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(bbm_pkg::LATENCY) done)
		else $error("item did not come out after the pipeline latency");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, bbm_pkg::LATENCY))
		else $error("result without an accepted item");

	a_inside_no_growth: assert property (@(posedge clk) disable iff (!arst_n)
		(done && metrics.b_inside_a) |-> (metrics.expansion == '0))
		else $error("b inside a but expansion nonzero");

	a_overlap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (metrics.overlap_area <= metrics.volume_a))
		else $error("overlap larger than area of a");

endmodule

// ===== tb/bounding_box_metrics_tb.sv =====
module bounding_box_metrics_tb;

	localparam int COORD_W = bbm_pkg::COORD_W;
	localparam int VOL_W = bbm_pkg::VOL_W;
	localparam int ROOT_W = bbm_pkg::ROOT_W;
	localparam int AXES_MAX = bbm_pkg::AXES_MAX;
	localparam int LATENCY = bbm_pkg::LATENCY;

	typedef bbm_pkg::boxes_t boxes_t;
	typedef bbm_pkg::metrics_t metrics_t;

	localparam int DIMS = 2;
	localparam int RAND_PER_PHASE = 530;
	localparam int CYCLE_LIMIT = 100000;
	localparam logic [VOL_W-1:0] FULL_AREA = 32'd4294836225;

	typedef struct {
		boxes_t boxes;
		bit typed;
		metrics_t want;
	} stim_row_t;

	typedef enum {MIX_RANDOM, MIX_CLUSTER, MIX_NESTED, MIX_DEGENERATE, MIX_CORNER} stim_mix_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	boxes_t boxes;
	logic done;
	metrics_t metrics;

	bit want_typed;
	metrics_t want_metrics;
	metrics_t pending_metrics[$];
	stim_row_t box_table[$];
	int mismatches = 0;
	int cycle_count = 0;

	bounding_box_metrics #(.DIMENSIONS(DIMS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.boxes(boxes),
		.done(done),
		.metrics(metrics)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic metrics_t predict_metrics(boxes_t b);
		longint ends[8];
		longint alo, ahi, blo, bhi, olen, diff;
		longint vol_a, vol_env, vol_ovl;
		longint unsigned dist_sq, root, trial;
		bit ovl_ok, b_in_a;
		int n_axes, ax, k;
		metrics_t m;
		for (k = 0; k < 8; k++) begin
			ends[k] = $signed(b[$bits(boxes_t)-1-COORD_W*k -: COORD_W]);
		end
		n_axes = DIMS > AXES_MAX ? AXES_MAX : (DIMS < 1 ? 1 : DIMS);
		vol_a = 1;
		vol_env = 1;
		vol_ovl = 1;
		dist_sq = 0;
		ovl_ok = 1'b1;
		b_in_a = 1'b1;
		for (ax = 0; ax < n_axes; ax++) begin
			alo = ends[2*ax] < ends[2*ax+1] ? ends[2*ax] : ends[2*ax+1];
			ahi = ends[2*ax] < ends[2*ax+1] ? ends[2*ax+1] : ends[2*ax];
			blo = ends[4+2*ax] < ends[5+2*ax] ? ends[4+2*ax] : ends[5+2*ax];
			bhi = ends[4+2*ax] < ends[5+2*ax] ? ends[5+2*ax] : ends[4+2*ax];
			vol_a = vol_a * (ahi - alo);
			vol_env = vol_env * ((ahi > bhi ? ahi : bhi) - (alo < blo ? alo : blo));
			olen = (ahi < bhi ? ahi : bhi) - (alo > blo ? alo : blo);
			if (olen <= 0)
				ovl_ok = 1'b0;
			else
				vol_ovl = vol_ovl * olen;
			if (blo < alo || bhi > ahi)
				b_in_a = 1'b0;
			diff = (alo + ahi) - (blo + bhi);
			dist_sq = dist_sq + longint'(diff * diff);
		end
		// bitwise integer square root, msb first
		root = 0;
		for (k = ROOT_W - 1; k >= 0; k--) begin
			trial = root | (longint'(1) << k);
			if (trial * trial <= dist_sq)
				root = trial;
		end
		m.volume_a = vol_a[VOL_W-1:0];
		m.expansion = vol_env[VOL_W-1:0] - vol_a[VOL_W-1:0];
		m.overlap_area = ovl_ok ? vol_ovl[VOL_W-1:0] : '0;
		m.b_inside_a = b_in_a;
		m.centroid_distance = root[ROOT_W-1:0];
		return m;
	endfunction

	function automatic boxes_t make_boxes(int ax0, int ax1, int ay0, int ay1,
			int bx0, int bx1, int by0, int by1);
		boxes_t b;
		b.box_a_x_end0 = ax0[15:0];
		b.box_a_x_end1 = ax1[15:0];
		b.box_a_y_end0 = ay0[15:0];
		b.box_a_y_end1 = ay1[15:0];
		b.box_b_x_end0 = bx0[15:0];
		b.box_b_x_end1 = bx1[15:0];
		b.box_b_y_end0 = by0[15:0];
		b.box_b_y_end1 = by1[15:0];
		return b;
	endfunction

	function automatic boxes_t rand_boxes();
		logic [31:0] word;
		int ends[8];
		int base, lo, hi, ax, k, r;
		stim_mix_t mix;
		boxes_t b;
		r = int'($urandom_range(0, 9));
		mix = r < 3 ? MIX_RANDOM : r < 6 ? MIX_CLUSTER : r < 8 ? MIX_NESTED :
			r < 9 ? MIX_DEGENERATE : MIX_CORNER;
		for (k = 0; k < 8; k++) begin
			word = $urandom;
			ends[k] = $signed(word[15:0]);
		end
		case (mix)
		MIX_CLUSTER, MIX_NESTED: begin
			for (ax = 0; ax < AXES_MAX; ax++) begin
				base = int'($urandom_range(0, 65535 - 256)) - 32768;
				ends[2*ax] = base + int'($urandom_range(0, 128));
				ends[2*ax+1] = base + int'($urandom_range(0, 128));
				ends[4+2*ax] = base + int'($urandom_range(0, 128));
				ends[5+2*ax] = base + int'($urandom_range(0, 128));
				if (mix == MIX_NESTED) begin
					lo = ends[2*ax] < ends[2*ax+1] ? ends[2*ax] : ends[2*ax+1];
					hi = ends[2*ax] < ends[2*ax+1] ? ends[2*ax+1] : ends[2*ax];
					ends[4+2*ax] = lo + int'($urandom_range(0, hi - lo));
					ends[5+2*ax] = lo + int'($urandom_range(0, hi - lo));
				end
			end
		end
		MIX_DEGENERATE: begin
			k = int'($urandom_range(0, 3));
			ends[2*k+1] = ends[2*k];
		end
		MIX_CORNER: begin
			for (k = 0; k < 8; k++) begin
				case ($urandom_range(0, 4))
				0: ends[k] = -32768;
				1: ends[k] = 32767;
				2: ends[k] = 0;
				3: ends[k] = -1;
				default: ends[k] = 1;
				endcase
			end
		end
		default: ;
		endcase
		for (k = 0; k < 8; k++) begin
			b[$bits(boxes_t)-1-COORD_W*k -: COORD_W] = ends[k][15:0];
		end
		return b;
	endfunction

	task automatic add_row(boxes_t b, bit typed, metrics_t want);
		stim_row_t row;
		row.boxes = b;
		row.typed = typed;
		row.want = want;
		box_table.push_back(row);
	endtask

	task automatic send_item(stim_row_t row, int idle_pct);
		@(negedge clk);
		while (int'($urandom_range(0, 99)) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		boxes <= row.boxes;
		want_typed <= row.typed;
		want_metrics <= row.want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		metrics_t exp_m;
		if (arst_n) begin
			if (start && !busy)
				pending_metrics.push_back(want_typed ? want_metrics : predict_metrics(boxes));
			if ($isunknown(done)) begin
				$display("%0t: done unknown: expected 0 or 1, got %b", $time, done);
				mismatches++;
			end else if (done) begin
				if (pending_metrics.size() == 0) begin
					$display("%0t: unexpected result: expected none, got %p", $time, metrics);
					mismatches++;
				end else begin
					exp_m = pending_metrics.pop_front();
					check_field("volume_a", 64'(exp_m.volume_a), 64'(metrics.volume_a));
					check_field("expansion", 64'(exp_m.expansion), 64'(metrics.expansion));
					check_field("overlap_area", 64'(exp_m.overlap_area),
						64'(metrics.overlap_area));
					check_field("b_inside_a", 64'(exp_m.b_inside_a), 64'(metrics.b_inside_a));
					check_field("centroid_distance", 64'(exp_m.centroid_distance),
						64'(metrics.centroid_distance));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_metrics.size());
			$display("bounding_box_metrics regression: fail");
			$finish;
		end
	end

	initial begin
		int phase, idle_pct, n;
		stim_row_t row;
		arst_n = 1'b0;
		start = 1'b0;
		boxes = '0;
		want_typed = 1'b0;
		want_metrics = '0;

		// zero boxes, full range, swapped ends, point inside, touching edge
		add_row(make_boxes(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			{32'd0, 32'd0, 32'd0, 1'b1, 18'd0});
		add_row(make_boxes(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767), 1'b1,
			{FULL_AREA, 32'd0, FULL_AREA, 1'b1, 18'd0});
		add_row(make_boxes(32767, -32768, 32767, -32768, -32768, 32767, 32767, -32768), 1'b1,
			{FULL_AREA, 32'd0, FULL_AREA, 1'b1, 18'd0});
		add_row(make_boxes(-32768, 32767, -32768, 32767, 0, 0, 0, 0), 1'b1,
			{FULL_AREA, 32'd0, 32'd0, 1'b1, 18'd1});
		add_row(make_boxes(0, 10, 0, 10, 10, 20, 0, 10), 1'b1,
			{32'd100, 32'd100, 32'd0, 1'b0, 18'd20});
		// the rest through the predictor
		add_row(make_boxes(0, 10, 0, 10, 10, 20, 10, 20), 1'b0, '0);
		add_row(make_boxes(-100, 100, -100, 100, -5, 7, 3, 50), 1'b0, '0);
		add_row(make_boxes(-5, 7, 3, 50, -100, 100, -100, 100), 1'b0, '0);
		add_row(make_boxes(40, -20, 90, 10, 60, 0, -30, 25), 1'b0, '0);
		add_row(make_boxes(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768),
			1'b0, '0);
		add_row(make_boxes(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767),
			1'b0, '0);
		add_row(make_boxes(5, 5, -10, 10, 0, 10, 0, 4), 1'b0, '0);
		add_row(make_boxes(0, 50, 0, 50, 0, 20, 50, 0), 1'b0, '0);
		add_row(make_boxes(0, 50, 0, 50, 10, 20, 0, 51), 1'b0, '0);
		add_row(make_boxes(-300, -200, -7000, -6000, -250, -150, -6500, -6400), 1'b0, '0);
		add_row(make_boxes(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767),
			1'b0, '0);

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		foreach (box_table[i])
			send_item(box_table[i], 24);
		row.typed = 1'b0;
		row.want = '0;
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = phase == 0 ? 24 : (phase == 1 ? 50 : 0);
			for (n = 0; n < RAND_PER_PHASE; n++) begin
				row.boxes = rand_boxes();
				send_item(row, idle_pct);
			end
		end
		@(negedge clk);
		start <= 1'b0;

		while (pending_metrics.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && pending_metrics.size() == 0) begin
			$display("bounding_box_metrics regression: pass");
		end else begin
			$display("%0t: %0d mismatches, %0d results missing", $time, mismatches,
				pending_metrics.size());
			$display("bounding_box_metrics regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bbm_pkg.sv
rtl/bbm_geom.sv
rtl/bbm_sqrt.sv
rtl/bounding_box_metrics.sv
tb/bounding_box_metrics_tb.sv
